@@ hdl/akms_pkg.sv @@
package akms_pkg;

   localparam int DEF_MAX_KEY_BASES = 64;
   localparam int DEF_POSITION_BITS = 20;

   // edit costs saturate at max_edits + 1, at most 64
   localparam int COST_BITS      = 7;
   localparam int MAX_COST       = 64;
   localparam int EDITS_BITS     = 6;
   localparam int KEY_LEN_BITS   = 7;
   localparam int KEY_WORD_BITS  = 64;
   localparam int LIMIT_BITS     = 20;
   localparam int MATCH_END_BITS = 20;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 64;

   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LOW    = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_HIGH   = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_KEY_LENGTH = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAX_EDITS  = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_LIMIT      = 3'd4;

   localparam logic [2:0] BASE_OTHER = 3'd4;

   typedef struct packed {
      logic [2:0] base_code;
      logic       read_first;
      logic       read_last;
   } req_item_type;

   typedef struct packed {
      logic                      match_found;
      logic [MATCH_END_BITS-1:0] match_end;
   } rsp_item_type;

   // one read base traveling down the cell row
   typedef struct packed {
      logic                 valid;
      logic                 fresh;
      logic                 last;
      logic [2:0]           base;
      logic [COST_BITS-1:0] diag;
      logic [COST_BITS-1:0] above;
      logic [COST_BITS-1:0] tail_cost;
   } cell_token_type;

endpackage

@@ hdl/approx_key_match_stream.sv @@
// Approximate key search over a streamed read. One read base is taken per item and
// ripples down a row of MAX_KEY_BASES cells, one cell per key position, each holding
// its entry of the edit-distance column; a new base enters the row every cycle while
// the result is not stalled, so the block accepts one item per clock. The result of a
// read (found flag and the zero-based position where the first match within
// search_limit ends) shows on rsp_valid once its last base has passed every cell:
// each cell registers the base once, the first cell at the accepting edge, and the
// output register in the tail follows the last cell. A stalled result holds the whole
// row, and input stall follows it. Configuration is written through the csr_ port
// while no item is in flight; no clearing pass is needed after reset.
module approx_key_match_stream import akms_pkg::*; #(
   parameter int MAX_KEY_BASES = DEF_MAX_KEY_BASES,
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  req_item_type              req_item,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output rsp_item_type              rsp_item,
   input  logic                      csr_write,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int LEN_BITS = $clog2(MAX_KEY_BASES + 1);

   logic [KEY_WORD_BITS-1:0] key_low_ff, key_high_ff;
   logic [KEY_LEN_BITS-1:0]  key_length_ff;
   logic [EDITS_BITS-1:0]    max_edits_ff;
   logic [LIMIT_BITS-1:0]    limit_ff;
   logic                     after_last_ff;

   logic                     advance;
   logic [LEN_BITS-1:0]      len_eff;
   logic [COST_BITS-1:0]     cap;
   logic [8:0]               key_length_ext;
   cell_token_type           chain [MAX_KEY_BASES+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         key_low_ff    <= '0;
         key_high_ff   <= '0;
         key_length_ff <= KEY_LEN_BITS'(16);
         max_edits_ff  <= EDITS_BITS'(2);
         limit_ff      <= '1;
      end else if (csr_write) begin
         case (csr_index)
            CSR_KEY_LOW: begin
               key_low_ff <= csr_wdata;
            end
            CSR_KEY_HIGH: begin
               key_high_ff <= csr_wdata;
            end
            CSR_KEY_LENGTH: begin
               key_length_ff <= csr_wdata[KEY_LEN_BITS-1:0];
            end
            CSR_MAX_EDITS: begin
               max_edits_ff <= csr_wdata[EDITS_BITS-1:0];
            end
            CSR_LIMIT: begin
               limit_ff <= csr_wdata[LIMIT_BITS-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      key_length_ext = 9'(key_length_ff);
      if (key_length_ext == 9'd0) begin
         len_eff = LEN_BITS'(1);
      end else if (key_length_ext > 9'(MAX_KEY_BASES)) begin
         len_eff = LEN_BITS'(MAX_KEY_BASES);
      end else begin
         len_eff = LEN_BITS'(key_length_ext);
      end
      cap = COST_BITS'(max_edits_ff) + COST_BITS'(1);
   end

   assign advance   = !rsp_valid || !rsp_stall;
   assign req_stall = !advance;

   // a read also restarts on the base after a read_last
   always_ff @(posedge clock) begin
      if (reset) begin
         after_last_ff <= 1'b1;
      end else if (advance && req_valid) begin
         after_last_ff <= req_item.read_last;
      end
   end

   always_comb begin
      chain[0]           = '0;
      chain[0].valid     = req_valid;
      chain[0].fresh     = req_item.read_first || after_last_ff;
      chain[0].last      = req_item.read_last;
      chain[0].base      = req_item.base_code;
   end

   for (genvar g = 0; g < MAX_KEY_BASES; g++) begin : g_cell
      logic [1:0] key_base;

      if (g < 32) begin : g_low
         assign key_base = key_low_ff[2*g +: 2];
      end else if (g < 64) begin : g_high
         assign key_base = key_high_ff[2*(g-32) +: 2];
      end else begin : g_none
         assign key_base = 2'b00;
      end

      akms_cell #(
         .CELL_INDEX (g),
         .LEN_BITS   (LEN_BITS)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .key_base  (key_base),
         .len_eff   (len_eff),
         .cap       (cap),
         .token_in  (chain[g]),
         .token_out (chain[g+1])
      );
   end

   akms_tail #(
      .POSITION_BITS (POSITION_BITS)
   ) u_tail (
      .clock        (clock),
      .reset        (reset),
      .advance      (advance),
      .token        (chain[MAX_KEY_BASES]),
      .max_edits    (max_edits_ff),
      .search_limit (limit_ff),
      .rsp_valid    (rsp_valid),
      .rsp_item     (rsp_item)
   );

endmodule

@@ hdl/akms_cell.sv @@
module akms_cell import akms_pkg::*; #(
   parameter int CELL_INDEX = 0,
   parameter int LEN_BITS   = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 advance,
   input  logic [1:0]           key_base,
   input  logic [LEN_BITS-1:0]  len_eff,
   input  logic [COST_BITS-1:0] cap,
   input  cell_token_type       token_in,
   output cell_token_type       token_out
);

   localparam int INIT = CELL_INDEX + 1;

   logic [COST_BITS-1:0] col_ff, col_in;
   cell_token_type       token_ff, token_in_next;
   logic [COST_BITS-1:0] init_val, old_val, min_val, raw_val, new_val;
   logic                 active, is_tail, is_match;

   always_comb begin
      // a fresh column entry is i+1; anything at or above the largest cap acts the same,
      // so deep entries are clipped there and stay correct if the edit bound changes
      if (INIT > MAX_COST) begin
         init_val = COST_BITS'(MAX_COST);
      end else begin
         init_val = COST_BITS'(INIT);
      end
      old_val  = token_in.fresh ? init_val : col_ff;
      active   = LEN_BITS'(CELL_INDEX) < len_eff;
      is_tail  = LEN_BITS'(CELL_INDEX + 1) == len_eff;
      is_match = (token_in.base < BASE_OTHER) && (token_in.base[1:0] == key_base);

      min_val = token_in.diag;
      if (token_in.above < min_val) begin
         min_val = token_in.above;
      end
      if (old_val < min_val) begin
         min_val = old_val;
      end
      raw_val = is_match ? token_in.diag : min_val + COST_BITS'(1);
      new_val = (raw_val > cap) ? cap : raw_val;

      col_in = active ? new_val : old_val;

      token_in_next           = token_in;
      token_in_next.diag      = old_val;
      token_in_next.above     = new_val;
      token_in_next.tail_cost = is_tail ? new_val : token_in.tail_cost;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         token_ff <= '0;
      end else if (advance) begin
         token_ff <= token_in_next;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && token_in.valid) begin
         col_ff <= col_in;
      end
   end

   assign token_out = token_ff;

endmodule

@@ hdl/akms_tail.sv @@
module akms_tail import akms_pkg::*; #(
   parameter int POSITION_BITS = DEF_POSITION_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  advance,
   input  cell_token_type        token,
   input  logic [EDITS_BITS-1:0] max_edits,
   input  logic [LIMIT_BITS-1:0] search_limit,
   output logic                  rsp_valid,
   output rsp_item_type          rsp_item
);

   localparam int CMP_BITS = (POSITION_BITS > LIMIT_BITS) ? POSITION_BITS : LIMIT_BITS;

   logic [POSITION_BITS-1:0] pos_ff, pos_in;
   logic [POSITION_BITS-1:0] hitpos_ff, hitpos_in;
   logic                     hit_ff, hit_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_item_type             rsp_item_ff, rsp_item_in;
   logic [POSITION_BITS-1:0] pos_cur;

   always_comb begin
      pos_cur   = token.fresh ? '0 : pos_ff;
      hit_in    = token.fresh ? 1'b0 : hit_ff;
      hitpos_in = token.fresh ? '0 : hitpos_ff;

      if (!hit_in && (token.tail_cost <= COST_BITS'(max_edits))
          && (CMP_BITS'(pos_cur) < CMP_BITS'(search_limit))) begin
         hit_in    = 1'b1;
         hitpos_in = pos_cur;
      end

      // position saturates at the top of its range
      pos_in = (pos_cur != '1) ? pos_cur + POSITION_BITS'(1) : pos_cur;

      rsp_valid_in            = token.valid && token.last;
      rsp_item_in.match_found = hit_in;
      rsp_item_in.match_end   = hit_in ? MATCH_END_BITS'(CMP_BITS'(hitpos_in)) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         hit_ff       <= 1'b0;
         hitpos_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= rsp_valid_in;
         if (token.valid) begin
            pos_ff    <= pos_in;
            hit_ff    <= hit_in;
            hitpos_ff <= hitpos_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule
